[src/rational_arith_unit_assert.svh]
// Assertion macros for the rational arithmetic unit
`ifndef RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RATIONAL_ARITH_UNIT_ASSERT_SVH
`define RAU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RAU_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[src/rau_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants for the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;
    localparam int MAG_WIDTH = 31;
    localparam int PROD_W    = 2 * MAG_WIDTH + 1;
    localparam int OUT_W     = 63;
    localparam int CNT_W     = $clog2(PROD_W + 1);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_SUB = 2'd1;
    localparam logic [1:0] CMD_MUL = 2'd2;
    localparam logic [1:0] CMD_DIV = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL0, ST_MUL1, ST_MUL2, ST_COMB,
        ST_GCD_START, ST_GCD_WAIT, ST_DIVN_START, ST_DIVN_WAIT,
        ST_DIVD_START, ST_DIVD_WAIT, ST_OUT
    } t_state;
endpackage

[src/rau_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_divider
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rau_divider
    import rau_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_dividend,
    input  logic [PROD_W-1:0] i_divisor,
    output logic              o_busy,
    output logic              o_done,
    output logic [PROD_W-1:0] o_quot,
    output logic [PROD_W-1:0] o_rem
);
    logic [PROD_W-1:0] r_q, n_q, r_d;
    logic [PROD_W:0]   r_r, n_r, w_sh, w_diff;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy, r_done;

    always_comb begin
        w_sh   = {r_r[PROD_W-1:0], r_q[PROD_W-1]};
        w_diff = w_sh - {1'b0, r_d};
        n_q    = {r_q[PROD_W-2:0], ~w_diff[PROD_W]};
        n_r    = w_diff[PROD_W] ? w_sh : w_diff;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                r_r    <= '0;
                r_cnt  <= CNT_W'(PROD_W);
            end else if (r_busy) begin
                r_q   <= n_q;
                r_r   <= n_r;
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_r[PROD_W-1:0];
endmodule

[src/rau_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_seq
// Sequencer: cross products, sign logic, Euclid loop and reduction.
// ----------------------------------------------------------------------------
module rau_seq
    import rau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [1:0]           i_cmd,
    input  logic                 i_a_neg,
    input  logic [MAG_WIDTH-1:0] i_a_num,
    input  logic [MAG_WIDTH-1:0] i_a_den,
    input  logic                 i_b_neg,
    input  logic [MAG_WIDTH-1:0] i_b_num,
    input  logic [MAG_WIDTH-1:0] i_b_den,
    input  logic                 i_out_ready,
    output logic                 o_idle,
    output logic                 o_valid,
    output logic                 o_neg,
    output logic [PROD_W-1:0]    o_num,
    output logic [PROD_W-1:0]    o_den,
    output logic                 o_dz
);
    t_state r_state, n_state;
    logic [1:0]             r_cmd;
    logic                   r_an, r_bn, r_neg, r_dz;
    logic [MAG_WIDTH-1:0]   r_ap, r_aq, r_bp, r_bq;
    logic [PROD_W-1:0]      r_p0, r_p1, r_p2, r_num, r_den, r_x, r_y;
    logic [MAG_WIDTH-1:0]   w_ma, w_mb;
    logic [2*MAG_WIDTH-1:0] w_mul;
    logic [PROD_W-1:0]      w_prod;
    logic                   w_div_start, w_div_busy, w_div_done;
    logic [PROD_W-1:0]      w_dvd, w_dvs, w_quot, w_rem;

    assign w_mul  = w_ma * w_mb;
    assign w_prod = {1'b0, w_mul};

    always_comb begin
        w_ma = r_aq;
        w_mb = r_bq;
        case (r_state)
            ST_MUL1: begin
                w_ma = r_ap;
                w_mb = (r_cmd == CMD_MUL || r_cmd == CMD_DIV) ? r_bp : r_bq;
            end
            ST_MUL2: begin
                w_ma = r_aq;
                w_mb = r_bp;
            end
            default: ;
        endcase
    end

    always_comb begin
        w_dvd = r_x;
        w_dvs = r_y;
        case (r_state)
            ST_DIVN_START: w_dvd = r_num;
            ST_DIVD_START: w_dvd = r_den;
            default: ;
        endcase
        if (r_state == ST_DIVN_START || r_state == ST_DIVD_START)
            w_dvs = r_x;
    end

    always_comb begin
        n_state     = r_state;
        w_div_start = 1'b0;
        case (r_state)
            ST_IDLE:       if (i_start) n_state = ST_MUL0;
            ST_MUL0:       n_state = ST_MUL1;
            ST_MUL1:       n_state = ST_MUL2;
            ST_MUL2:       n_state = ST_COMB;
            ST_COMB:       n_state = ST_GCD_START;
            ST_GCD_START: begin
                if (r_num == '0) n_state = ST_OUT;
                else if (r_y == '0) n_state = ST_DIVN_START;
                else begin
                    w_div_start = 1'b1;
                    n_state = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT:   if (w_div_done) n_state = ST_GCD_START;
            ST_DIVN_START: begin
                w_div_start = 1'b1;
                n_state = ST_DIVN_WAIT;
            end
            ST_DIVN_WAIT:  if (w_div_done) n_state = ST_DIVD_START;
            ST_DIVD_START: begin
                w_div_start = 1'b1;
                n_state = ST_DIVD_WAIT;
            end
            ST_DIVD_WAIT:  if (w_div_done) n_state = ST_OUT;
            ST_OUT:        if (i_out_ready) n_state = ST_IDLE;
            default:       n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else          r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_cmd <= i_cmd;
                r_an  <= i_a_neg;
                r_ap  <= i_a_num;
                r_aq  <= i_a_den;
                r_bn  <= (i_cmd == CMD_SUB) ? ~i_b_neg : i_b_neg;
                if (i_cmd == CMD_DIV) begin
                    r_bp <= i_b_den;
                    r_bq <= i_b_num;
                end else begin
                    r_bp <= i_b_num;
                    r_bq <= i_b_den;
                end
                r_dz <= (i_cmd == CMD_DIV) && (i_b_num == '0);
            end
            ST_MUL0: r_p0 <= w_prod;
            ST_MUL1: r_p1 <= w_prod;
            ST_MUL2: r_p2 <= w_prod;
            ST_COMB: begin
                r_den <= r_p0;
                if (r_dz) begin
                    r_num <= '0;
                    r_neg <= 1'b0;
                end else if (r_cmd == CMD_MUL || r_cmd == CMD_DIV) begin
                    r_num <= r_p1;
                    r_neg <= r_an ^ r_bn;
                end else if (r_an == r_bn) begin
                    r_num <= r_p1 + r_p2;
                    r_neg <= r_an;
                end else if (r_p1 > r_p2) begin
                    r_num <= r_p1 - r_p2;
                    r_neg <= r_an;
                end else begin
                    r_num <= r_p2 - r_p1;
                    r_neg <= r_bn;
                end
            end
            ST_GCD_START: begin
                if (r_num == '0) begin
                    r_neg <= 1'b0;
                    r_den <= PROD_W'(1);
                end
            end
            ST_GCD_WAIT: if (w_div_done) begin
                r_x <= r_y;
                r_y <= w_rem;
            end
            ST_DIVN_WAIT: if (w_div_done) r_num <= w_quot;
            ST_DIVD_WAIT: if (w_div_done) r_den <= w_quot;
            default: ;
        endcase
        if (r_state == ST_COMB) begin
            r_x <= (r_cmd == CMD_MUL || r_cmd == CMD_DIV) ? r_p1
                 : (r_an == r_bn) ? r_p1 + r_p2
                 : (r_p1 > r_p2) ? r_p1 - r_p2 : r_p2 - r_p1;
            r_y <= r_p0;
        end
    end

    // MUL0 den aq*bq; MUL1 ap*bp (mul/div) or ap*bq (add/sub); MUL2 aq*bp
    rau_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd),
        .i_divisor  (w_dvs),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign o_idle  = (r_state == ST_IDLE) && !w_div_busy;
    assign o_valid = (r_state == ST_OUT);
    assign o_neg   = r_neg;
    assign o_num   = r_num;
    assign o_den   = r_den;
    assign o_dz    = r_dz;
endmodule

[src/rational_arith_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_unit
// Sign-magnitude rational add/sub/mul/div with GCD-reduced result.
// ----------------------------------------------------------------------------
// channel | signals                          | direction
// in      | i_valid/o_ready, cmd, a_*, b_*   | input transaction
// out     | o_valid/i_ready, r_*, div_zero   | output transaction
// Accept state, multiplier states MUL0, MUL1 and MUL2 and a combine state,
// then Euclid steps (a start state plus a wait on the shared 63-bit
// divider), a final check and two reducing divides on that divider.
// A zero numerator goes straight to the result.
// Synchronous active-low reset returns the sequencer to idle.
// A stalled result holds the unit; o_ready is low until it is taken.
// ----------------------------------------------------------------------------
module rational_arith_unit
    import rau_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [1:0]           i_cmd,
    input  logic                 i_a_neg,
    input  logic [MAG_WIDTH-1:0] i_a_num,
    input  logic [MAG_WIDTH-1:0] i_a_den,
    input  logic                 i_b_neg,
    input  logic [MAG_WIDTH-1:0] i_b_num,
    input  logic [MAG_WIDTH-1:0] i_b_den,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_r_neg,
    output logic [OUT_W-1:0]     o_r_num,
    output logic [OUT_W-1:0]     o_r_den,
    output logic                 o_div_zero
);
    logic              w_idle;
    logic [PROD_W-1:0] w_num, w_den;

    rau_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_valid && w_idle),
        .i_cmd       (i_cmd),
        .i_a_neg     (i_a_neg),
        .i_a_num     (i_a_num),
        .i_a_den     (i_a_den),
        .i_b_neg     (i_b_neg),
        .i_b_num     (i_b_num),
        .i_b_den     (i_b_den),
        .i_out_ready (i_ready),
        .o_idle      (w_idle),
        .o_valid     (o_valid),
        .o_neg       (o_r_neg),
        .o_num       (w_num),
        .o_den       (w_den),
        .o_dz        (o_div_zero)
    );

    assign o_ready = w_idle;
    assign o_r_num = OUT_W'(w_num);
    assign o_r_den = OUT_W'(w_den);
endmodule

[src/rau_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks for the rational arithmetic unit.
// ----------------------------------------------------------------------------
`include "rational_arith_unit_assert.svh"
module rau_checker
    import rau_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic             o_r_neg,
    input logic [OUT_W-1:0] o_r_num,
    input logic [OUT_W-1:0] o_r_den,
    input logic             o_div_zero
);
    `RAU_ASSERT(a_excl, i_clk, i_rst_n, !(o_ready && o_valid), "ready while result pending")
    `RAU_ASSERT(a_hold, i_clk, i_rst_n, o_valid && !i_ready |=> o_valid && $stable(o_r_num), "result dropped")
    `RAU_ASSERT(a_zero, i_clk, i_rst_n, o_valid && o_r_num == '0 |-> !o_r_neg && o_r_den == OUT_W'(1), "zero not canonical")
    `RAU_ASSERT(a_dz, i_clk, i_rst_n, o_valid && o_div_zero |-> o_r_num == '0, "div by zero nonzero")
    `RAU_ASSERT_NR(a_rst, i_clk, !i_rst_n |=> !o_valid, "valid after reset")
endmodule

bind rational_arith_unit rau_checker u_chk (.*);
